FILE: design/lpf_pkg.sv
`default_nettype none

package lpf_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int RANGE_W    = 20;
    localparam int QUAL_W     = 8;
    localparam int LOCAL_W    = 21;
    localparam int MAP_W      = 24;
    localparam int STR_W      = 6;
    localparam int SIN_W      = 15;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Quality is scaled down by this many bits to form strength
    localparam int QUALITY_SHIFT = 2;

    // Default log2 of the quarter-wave sine table size
    localparam int SINE_TABLE_BITS_DEF = 10;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Forward half: bearing at or below the first, or at or above the second
    localparam logic [ANGLE_W-1:0] ANGLE_FWD_END  = 16'd16384;
    localparam logic [ANGLE_W-1:0] ANGLE_REAR_END = 16'd49152;

    // Reset values of the configuration registers
    localparam logic [RANGE_W-1:0] RANGE_LOW_RST  = 20'd0;
    localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 20'd4000;

    // Largest strength value
    localparam logic [QUAL_W-1:0] STR_MAX = 8'd63;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW  = 2'd0,
        CFG_RANGE_HIGH = 2'd1,
        CFG_ORIGIN_X   = 2'd2,
        CFG_ORIGIN_Y   = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

FILE: design/lpf_ifs.sv
`default_nettype none

// Measurement channel
interface lpf_in_if
    import lpf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ANGLE_W-1:0]   angle_q14;
    logic [RANGE_W-1:0]   distance_q2;
    logic [QUAL_W-1:0]    quality_raw;

    modport source (output valid, output angle_q14, output distance_q2,
                    output quality_raw, input ready);
    modport sink   (input valid, input angle_q14, input distance_q2,
                    input quality_raw, output ready);
endinterface

// Point result channel
interface lpf_out_if
    import lpf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [ANGLE_W-1:0]        bearing;
    logic [RANGE_W-1:0]        range_out;
    logic signed [LOCAL_W-1:0] local_x;
    logic signed [LOCAL_W-1:0] local_y;
    logic signed [MAP_W-1:0]   map_x;
    logic signed [MAP_W-1:0]   map_y;
    logic [STR_W-1:0]          strength;

    modport source (output valid, output bearing, output range_out, output local_x,
                    output local_y, output map_x, output map_y, output strength,
                    input ready);
    modport sink   (input valid, input bearing, input range_out, input local_x,
                    input local_y, input map_x, input map_y, input strength,
                    output ready);
endinterface

// Register write channel
interface lpf_cfg_if
    import lpf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lidar_point_filter_polar_to_xy_unit.sv
`default_nettype none

// Channel   Dir  Handshake      Contents
// i_pt      in   valid/ready    angle_q14, distance_q2, quality_raw
// o_pt      out  valid/ready    bearing, range_out, local_x/y, map_x/y, strength
// i_cfg     in   valid/ready    index, data (register write, always ready)
//
// One request per cycle while o_pt is not stalled; a kept point is registered in
// turn by the sine table read, the multiply, and the map offset and saturate
// stages before it is offered on o_pt. Rejected points produce no result
// and leave a bubble that later stages squeeze out.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register
// reset values. A stalled output holds its stage; earlier stages keep moving
// until they run into it, so i_pt.ready drops only when all three are full.
module lidar_point_filter_polar_to_xy_unit
    import lpf_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpf_in_if.sink     i_pt,
    lpf_out_if.source  o_pt,
    lpf_cfg_if.sink    i_cfg
);

    localparam int TB = SINE_TABLE_BITS;
    localparam logic [TB:0] TAB_N = (TB + 1)'(1) << TB;

    // ---------------- configuration registers ----------------
    logic [RANGE_W-1:0]      r_range_low;
    logic [RANGE_W-1:0]      r_range_high;
    logic signed [MAP_W-1:0] r_origin_x;
    logic signed [MAP_W-1:0] r_origin_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_RANGE_LOW:  r_range_low  <= i_cfg.data[RANGE_W-1:0];
                CFG_RANGE_HIGH: r_range_high <= i_cfg.data[RANGE_W-1:0];
                CFG_ORIGIN_X:   r_origin_x   <= $signed(i_cfg.data[MAP_W-1:0]);
                CFG_ORIGIN_Y:   r_origin_y   <= $signed(i_cfg.data[MAP_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || o_pt.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pt.ready = en1;

    // ---------------- stage 0: filter and table addresses ----------------
    logic [QUAL_W-1:0] str_raw;
    logic [STR_W-1:0]  str_sat;
    logic              keep;
    logic [TB:0]       tab_i;
    logic [TB:0]       addr_s;
    logic [TB:0]       addr_c;

    always_comb begin
        str_raw = i_pt.quality_raw >> QUALITY_SHIFT;
        str_sat = (str_raw > STR_MAX) ? STR_MAX[STR_W-1:0] : str_raw[STR_W-1:0];
        keep = (i_pt.distance_q2 > r_range_low) && (i_pt.distance_q2 < r_range_high)
            && (str_raw != '0)
            && ((i_pt.angle_q14 <= ANGLE_FWD_END) || (i_pt.angle_q14 >= ANGLE_REAR_END));
        tab_i  = {1'b0, i_pt.angle_q14[ANGLE_W-3 -: TB]};
        // odd quadrants read the table mirrored; cosine is a quarter turn ahead
        addr_s = i_pt.angle_q14[ANGLE_W-2] ? (TAB_N - tab_i) : tab_i;
        addr_c = i_pt.angle_q14[ANGLE_W-2] ? tab_i : (TAB_N - tab_i);
    end

    logic [SIN_W-1:0] sin_mag;
    logic [SIN_W-1:0] cos_mag;

    lpf_sin_rom #(
        .TABLE_BITS (TB)
    ) u_sin_rom (
        .i_clk    (i_clk),
        .i_en     (en1),
        .i_addr_a (addr_s),
        .i_addr_b (addr_c),
        .o_data_a (sin_mag),
        .o_data_b (cos_mag)
    );

    // ---------------- stage 1: input register ----------------
    logic [ANGLE_W-1:0] r_a1;
    logic [RANGE_W-1:0] r_r1;
    logic [STR_W-1:0]   r_str1;
    logic               r_neg_s1;
    logic               r_neg_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_pt.valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_a1     <= i_pt.angle_q14;
            r_r1     <= i_pt.distance_q2;
            r_str1   <= str_sat;
            r_neg_s1 <= i_pt.angle_q14[ANGLE_W-1];
            r_neg_c1 <= i_pt.angle_q14[ANGLE_W-1] ^ i_pt.angle_q14[ANGLE_W-2];
        end
    end

    // ---------------- stage 1 -> 2: scale by sine and cosine ----------------
    localparam int PROD_W = RANGE_W + SIN_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SIN_W - 1);

    logic [PROD_W-1:0]         prod_s;
    logic [PROD_W-1:0]         prod_c;
    logic [LOCAL_W-1:0]        mag_s;
    logic [LOCAL_W-1:0]        mag_c;
    logic signed [LOCAL_W-1:0] n_lx;
    logic signed [LOCAL_W-1:0] n_ly;

    always_comb begin
        prod_s = PROD_W'(r_r1) * PROD_W'(sin_mag) + ROUND_HALF;
        prod_c = PROD_W'(r_r1) * PROD_W'(cos_mag) + ROUND_HALF;
        mag_s  = {1'b0, prod_s[PROD_W-1 -: RANGE_W]};
        mag_c  = {1'b0, prod_c[PROD_W-1 -: RANGE_W]};
        n_lx   = r_neg_s1 ? -$signed(mag_s) : $signed(mag_s);
        n_ly   = r_neg_c1 ? -$signed(mag_c) : $signed(mag_c);
    end

    logic [ANGLE_W-1:0]        r_a2;
    logic [RANGE_W-1:0]        r_r2;
    logic [STR_W-1:0]          r_str2;
    logic signed [LOCAL_W-1:0] r_lx2;
    logic signed [LOCAL_W-1:0] r_ly2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_a2   <= r_a1;
            r_r2   <= r_r1;
            r_str2 <= r_str1;
            r_lx2  <= n_lx;
            r_ly2  <= n_ly;
        end
    end

    // ---------------- stage 2 -> 3: map offset with saturation ----------------
    localparam logic signed [MAP_W-1:0] MAP_MAX = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic signed [MAP_W-1:0] MAP_MIN = {1'b1, {(MAP_W-1){1'b0}}};

    logic signed [MAP_W:0]   sum_x;
    logic signed [MAP_W:0]   sum_y;
    logic signed [MAP_W-1:0] n_map_x;
    logic signed [MAP_W-1:0] n_map_y;

    always_comb begin
        sum_x = (MAP_W+1)'(r_origin_x) + (MAP_W+1)'(r_lx2);
        sum_y = (MAP_W+1)'(r_origin_y) + (MAP_W+1)'(r_ly2);
        if (sum_x[MAP_W] != sum_x[MAP_W-1]) begin
            n_map_x = sum_x[MAP_W] ? MAP_MIN : MAP_MAX;
        end else begin
            n_map_x = sum_x[MAP_W-1:0];
        end
        if (sum_y[MAP_W] != sum_y[MAP_W-1]) begin
            n_map_y = sum_y[MAP_W] ? MAP_MIN : MAP_MAX;
        end else begin
            n_map_y = sum_y[MAP_W-1:0];
        end
    end

    logic [ANGLE_W-1:0]        r_a3;
    logic [RANGE_W-1:0]        r_r3;
    logic [STR_W-1:0]          r_str3;
    logic signed [LOCAL_W-1:0] r_lx3;
    logic signed [LOCAL_W-1:0] r_ly3;
    logic signed [MAP_W-1:0]   r_mx3;
    logic signed [MAP_W-1:0]   r_my3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_a3   <= r_a2;
            r_r3   <= r_r2;
            r_str3 <= r_str2;
            r_lx3  <= r_lx2;
            r_ly3  <= r_ly2;
            r_mx3  <= n_map_x;
            r_my3  <= n_map_y;
        end
    end

    // ---------------- result channel ----------------
    assign o_pt.valid     = r_v3;
    assign o_pt.bearing   = r_a3;
    assign o_pt.range_out = r_r3;
    assign o_pt.local_x   = r_lx3;
    assign o_pt.local_y   = r_ly3;
    assign o_pt.map_x     = r_mx3;
    assign o_pt.map_y     = r_my3;
    assign o_pt.strength  = r_str3;

    // ---------------- assertions ----------------
    a_rst_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3))
        else $error("pipeline not empty after reset");

    a_str_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |-> (o_pt.strength != '0))
        else $error("kept point with zero strength");

    a_forward_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |-> ((o_pt.bearing <= ANGLE_FWD_END) || (o_pt.bearing >= ANGLE_REAR_END)))
        else $error("kept point outside forward half");

    a_local_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid |->
            (($signed({o_pt.local_x[LOCAL_W-1], o_pt.local_x})
                <= $signed({2'b00, o_pt.range_out}))
          && ($signed({o_pt.local_x[LOCAL_W-1], o_pt.local_x})
                >= -$signed({2'b00, o_pt.range_out}))
          && ($signed({o_pt.local_y[LOCAL_W-1], o_pt.local_y})
                <= $signed({2'b00, o_pt.range_out}))
          && ($signed({o_pt.local_y[LOCAL_W-1], o_pt.local_y})
                >= -$signed({2'b00, o_pt.range_out}))))
        else $error("local coordinate exceeds range");

endmodule

`default_nettype wire

FILE: design/lpf_sin_rom.sv
`default_nettype none

// Quarter-wave sine table, unsigned Q0.15 magnitudes, two registered read ports.
// Contents are built at elaboration from a fixed-point Taylor series.
module lpf_sin_rom
    import lpf_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [TABLE_BITS:0]   i_addr_a,
    input  wire logic [TABLE_BITS:0]   i_addr_b,
    output logic      [SIN_W-1:0]      o_data_a,
    output logic      [SIN_W-1:0]      o_data_b
);

    localparam int TAB_N = 1 << TABLE_BITS;

    typedef logic [SIN_W-1:0] t_rom [0:TAB_N];

    // Shift-and-subtract quotient, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(32768 * sin(k * pi / (2N))), capped at 32767
    function automatic logic [SIN_W-1:0] tab_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        d;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = ((64'(k) * HALF_PI_Q30) + 64'(TAB_N >> 1)) >> TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int i = 1; i <= 8; i++) begin
            d    = 64'((2 * i) * (2 * i + 1));
            term = div_u64((term * x2) >> 30, d);
            if (i[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SIN_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= TAB_N; k++) begin
            rom[k] = tab_entry(k);
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [SIN_W-1:0] r_data_a;
    logic [SIN_W-1:0] r_data_b;

    // Registered reads, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= ROM[i_addr_a];
            r_data_b <= ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
module tb_top;
    import lpf_pkg::*;

    localparam int TAB_BITS       = SINE_TABLE_BITS_DEF;
    localparam int TAB_N          = 1 << TAB_BITS;
    localparam int IDLE_PCT       = 11;
    localparam int HOLD_CYCLES    = 80;
    localparam int PIPE_FLUSH     = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0] range_q2;
        logic [QUAL_W-1:0]  quality;
    } t_meas;

    typedef struct packed {
        logic [ANGLE_W-1:0]        bearing;
        logic [RANGE_W-1:0]        range_out;
        logic signed [LOCAL_W-1:0] local_x;
        logic signed [LOCAL_W-1:0] local_y;
        logic signed [MAP_W-1:0]   map_x;
        logic signed [MAP_W-1:0]   map_y;
        logic [STR_W-1:0]          strength;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpf_in_if  meas_if ();
    lpf_out_if point_if ();
    lpf_cfg_if cfg_if ();

    lidar_point_filter_polar_to_xy_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (meas_if),
        .o_pt    (point_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the register file
    logic [RANGE_W-1:0]      lo_bound;
    logic [RANGE_W-1:0]      hi_bound;
    logic signed [MAP_W-1:0] org_x;
    logic signed [MAP_W-1:0] org_y;

    int unsigned sine_tab [0:TAB_N];

    t_meas  meas_q[$];     // measurements waiting to be sent
    t_point point_q[$];    // kept points still owed by the block

    bit meas_taken;
    bit steady;
    bit hold_req;
    bit hold_done;
    int hold_cnt;
    int err_cnt;
    int quiet_cycles;

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Point projection
    // ---------------------------------------------------------------

    // Quarter-wave entry: Q30 Taylor series of sin, rounded to Q15
    function automatic int unsigned quarter_sine(input int unsigned k);
        longint unsigned n, x, x2, term, d, v;
        longint acc;
        n = 64'd1 << TAB_BITS;
        x = (longint'(k) * HALF_PI_Q30 + (n >> 1)) >> TAB_BITS;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int i = 1; i <= 8; i++) begin
            d = (2 * i) * (2 * i + 1);
            term = ((term * x2) >> 30) / d;
            if (i % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        v = (longint'(acc) + (64'd1 << 14)) >> 15;
        if (v > 32767)
            v = 32767;
        return int'(v);
    endfunction

    function automatic int sine_q15(input logic [ANGLE_W-1:0] ang);
        int unsigned idx;
        int mag;
        idx = ang[13:0] >> (14 - TAB_BITS);
        mag = ang[14] ? sine_tab[TAB_N - idx] : sine_tab[idx];
        return ang[15] ? -mag : mag;
    endfunction

    // r * s / 2^15, magnitude rounded half up
    function automatic longint scaled(input logic [RANGE_W-1:0] r, input int s);
        longint mag, p;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        p = (longint'(r) * mag + 16384) >> 15;
        return (s < 0) ? -p : p;
    endfunction

    function automatic longint clamp_map(input longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic bit project_point(input t_meas m, output t_point p);
        int unsigned stren;
        logic [ANGLE_W-1:0] cos_ang;
        longint lx, ly, mx, my;
        p = '0;
        stren = m.quality >> QUALITY_SHIFT;
        if (!(m.range_q2 > lo_bound && m.range_q2 < hi_bound))
            return 1'b0;
        if (stren == 0)
            return 1'b0;
        if (!(m.angle <= ANGLE_FWD_END || m.angle >= ANGLE_REAR_END))
            return 1'b0;
        if (stren > STR_MAX)
            stren = STR_MAX;
        cos_ang = m.angle + 16'd16384;
        lx = scaled(m.range_q2, sine_q15(m.angle));
        ly = scaled(m.range_q2, sine_q15(cos_ang));
        mx = clamp_map(longint'(org_x) + lx);
        my = clamp_map(longint'(org_y) + ly);
        p.bearing   = m.angle;
        p.range_out = m.range_q2;
        p.local_x   = lx[LOCAL_W-1:0];
        p.local_y   = ly[LOCAL_W-1:0];
        p.map_x     = mx[MAP_W-1:0];
        p.map_y     = my[MAP_W-1:0];
        p.strength  = stren[STR_W-1:0];
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            err_cnt++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------
    // Measurement driver
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : meas_driver
        t_meas nxt;
        if (!meas_if.valid || meas_taken) begin
            if (meas_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = meas_q.pop_front();
                meas_if.valid       <= 1'b1;
                meas_if.angle_q14   <= nxt.angle;
                meas_if.distance_q2 <= nxt.range_q2;
                meas_if.quality_raw <= nxt.quality;
            end else begin
                meas_if.valid <= 1'b0;
            end
        end
    end

    // Result ready, with one long hold-off to back up the pipeline
    always @(negedge i_clk) begin : point_ready
        if (hold_cnt != 0) begin
            point_if.ready <= 1'b0;
            hold_cnt--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt = HOLD_CYCLES - 1;
            point_if.ready <= 1'b0;
        end else begin
            point_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted requests, check accepted results
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_meas  m;
        t_point want;
        bit     busy;
        meas_taken = i_rst_n && meas_if.valid && meas_if.ready;
        if (meas_taken) begin
            m.angle    = meas_if.angle_q14;
            m.range_q2 = meas_if.distance_q2;
            m.quality  = meas_if.quality_raw;
            if (project_point(m, want))
                point_q = {point_q, want};
        end

        if (i_rst_n && point_if.valid && point_if.ready) begin
            if (point_q.size() == 0) begin
                err_cnt++;
                $error("point result with none expected: bearing %0d range %0d",
                       point_if.bearing, point_if.range_out);
            end else begin
                want = point_q.pop_front();
                check_field("bearing", want.bearing, point_if.bearing);
                check_field("range_out", want.range_out, point_if.range_out);
                check_field("local_x", want.local_x, point_if.local_x);
                check_field("local_y", want.local_y, point_if.local_y);
                check_field("map_x", want.map_x, point_if.map_x);
                check_field("map_y", want.map_y, point_if.map_y);
                check_field("strength", want.strength, point_if.strength);
            end
        end

        // watchdog on cycles without any handshake
        busy = meas_taken || (point_if.valid && point_if.ready)
               || (cfg_if.valid && cfg_if.ready);
        quiet_cycles = busy ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_RANGE_LOW:  lo_bound = val[RANGE_W-1:0];
            CFG_RANGE_HIGH: hi_bound = val[RANGE_W-1:0];
            CFG_ORIGIN_X:   org_x = val;
            CFG_ORIGIN_Y:   org_y = val;
            default: ;
        endcase
    endtask

    // Write all four registers; range upper data bits carry junk
    task automatic load_regs(input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi,
                             input logic [MAP_W-1:0] ox, input logic [MAP_W-1:0] oy);
        write_reg(CFG_RANGE_LOW, {4'($urandom), lo});
        write_reg(CFG_RANGE_HIGH, {4'($urandom), hi});
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_point(input int ang, input int rng, input int qual);
        t_meas m;
        m.angle    = ang[ANGLE_W-1:0];
        m.range_q2 = rng[RANGE_W-1:0];
        m.quality  = qual[QUAL_W-1:0];
        meas_q = {meas_q, m};
    endtask

    // Mostly points that pass all filters; the rest are noise, sit at or next to a range bound, or miss one test
    task automatic add_random(input int count, input int keep_pct);
        t_meas m;
        int lo_i, hi_i, edge_d;
        bit open_win;
        repeat (count) begin
            lo_i = lo_bound;
            hi_i = hi_bound;
            open_win = hi_i > lo_i + 1;
            m.quality = 8'($urandom_range(255, 4));
            m.angle = $urandom_range(1) ? 16'($urandom_range(16384, 0))
                                        : 16'($urandom_range(65535, 49152));
            m.range_q2 = open_win ? 20'($urandom_range(hi_i - 1, lo_i + 1)) : 20'($urandom);
            if ($urandom_range(99) >= keep_pct) begin
                case ($urandom_range(3))
                    0: begin
                        m.angle    = 16'($urandom);
                        m.range_q2 = 20'($urandom);
                        m.quality  = 8'($urandom);
                    end
                    1: begin
                        case ($urandom_range(3))
                            0: edge_d = lo_i;
                            1: edge_d = lo_i + 1;
                            2: edge_d = hi_i - 1;
                            default: edge_d = hi_i;
                        endcase
                        m.range_q2 = edge_d[RANGE_W-1:0];
                    end
                    2: m.quality = 8'($urandom_range(3, 0));
                    default: m.angle = 16'($urandom_range(49151, 16385));
                endcase
            end
            meas_q = {meas_q, m};
        end
    endtask

    // Wait until every request is sent and every point has come back
    task automatic drain();
        while (meas_q.size() != 0 || meas_if.valid) @(posedge i_clk);
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        int lo_r, hi_r;
        i_rst_n = 1'b0;
        meas_if.valid = 1'b0;
        meas_if.angle_q14 = '0;
        meas_if.distance_q2 = '0;
        meas_if.quality_raw = '0;
        point_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_RANGE_LOW;
        cfg_if.data = '0;
        lo_bound = RANGE_LOW_RST;
        hi_bound = RANGE_HIGH_RST;
        org_x = '0;
        org_y = '0;
        for (int k = 0; k <= TAB_N; k++)
            sine_tab[k] = quarter_sine(k);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset window (0, 4000)
        add_point(0, 1000, 255);
        add_point(16384, 1000, 100);      // forward edge, kept
        add_point(16385, 1000, 100);      // just behind, dropped
        add_point(49151, 1000, 100);
        add_point(49152, 1000, 100);      // rear-side forward edge, kept
        add_point(65535, 3999, 255);
        add_point(32768, 2000, 200);
        add_point(8192, 0, 200);          // at lower bound
        add_point(8192, 1, 4);            // smallest strength
        add_point(8192, 3999, 3);         // quality shifts to zero
        add_point(8192, 4000, 200);       // at upper bound
        add_point(8192, 1048575, 255);
        add_point(60000, 2500, 0);
        add_point(4096, 3999, 252);
        add_point(61440, 3999, 128);
        add_point(1, 3999, 7);
        add_point(16383, 3999, 9);
        add_point(49153, 3999, 11);
        add_point(12345, 2, 64);
        add_point(0, 3999, 255);
        add_point(16384, 3999, 255);
        drain();

        // Full window, origin at the extremes: map sums saturate; long output stall
        load_regs(20'd0, 20'hFFFFF, 24'h7FFFFF, 24'h800000);
        add_random(250, 75);
        hold_req = 1'b1;
        drain();

        // Opposite extremes, no idling on either side
        load_regs(20'd0, 20'hFFFFF, 24'h800000, 24'h7FFFFF);
        steady = 1'b1;
        add_random(250, 75);
        drain();
        steady = 1'b0;

        // Empty windows keep nothing
        load_regs(20'd500, 20'd501, 24'd0, 24'd0);
        add_random(40, 80);
        drain();
        load_regs(20'd0, 20'd1, 24'h000100, 24'hFFFF00);
        add_random(40, 80);
        drain();
        load_regs(20'hFFFFF, 20'hFFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_random(40, 80);
        drain();
        load_regs(20'd900000, 20'd1000, 24'h800000, 24'h800000);
        add_random(40, 80);
        drain();

        // Narrow window, random origin
        load_regs(20'd1000, 20'd5000, 24'($urandom), 24'($urandom));
        add_random(250, 75);
        drain();

        // Random settings
        repeat (5) begin
            lo_r = $urandom_range(3000);
            hi_r = lo_r + $urandom_range(300000, 2);
            if (hi_r > 1048575)
                hi_r = 1048575;
            load_regs(lo_r[RANGE_W-1:0], hi_r[RANGE_W-1:0], 24'($urandom), 24'($urandom));
            add_random(220, 75);
            drain();
        end

        if (err_cnt == 0 && point_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
design/lpf_pkg.sv
design/lpf_ifs.sv
design/lpf_sin_rom.sv
design/lidar_point_filter_polar_to_xy_unit.sv
test/tb_top.sv
